[rtl/kmeans_cluster_refine_macros.svh]
// Assertion macros shared by the k-means refinement block.
// No dependencies; included by files that carry concurrent checks.
`ifndef KMEANS_CLUSTER_REFINE_MACROS_SVH
`define KMEANS_CLUSTER_REFINE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define KMCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define KMCR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kmcr_pkg.sv]
// Shared types and sizing constants for the k-means refinement block.
// No dependencies; imported by every module of the block but kmcr_ram.
`default_nettype none

package kmcr_pkg;

    // Sizing
    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 8;
    localparam int MAX_DIMS     = 8;
    localparam int COORD_WIDTH  = 32;

    localparam int PT_W    = $clog2(MAX_POINTS);
    localparam int CL_W    = $clog2(MAX_CLUSTERS);
    localparam int DM_W    = $clog2(MAX_DIMS);
    localparam int CNT_W   = PT_W + 1;
    localparam int SUM_W   = COORD_WIDTH + 16;
    localparam int DIF_W   = COORD_WIDTH + 1;
    localparam int PT_AW   = PT_W + DM_W;
    localparam int CT_AW   = CL_W + DM_W;
    localparam int NENT    = MAX_CLUSTERS * MAX_DIMS;
    localparam int NPTENT  = MAX_POINTS * MAX_DIMS;

    // Request codes on the command port
    typedef enum logic [1:0] {
        REQ_LDPT = 2'd0,
        REQ_LDCT = 2'd1,
        REQ_RUN  = 2'd2
    } t_req;

    // Classified commands held in the queue
    typedef enum logic [1:0] {
        CMD_LDPT,
        CMD_LDCT,
        CMD_RUN
    } t_cmd;

    typedef struct packed {
        t_cmd                    cmd;
        logic [PT_W-1:0]         idx;
        logic [DM_W-1:0]         dim;
        logic [COORD_WIDTH-1:0]  val;
    } t_qent;

    // Clamped configuration, as last indexes
    typedef struct packed {
        logic [PT_W-1:0]  n_last;
        logic [CL_W-1:0]  k_last;
        logic [DM_W-1:0]  d_last;
        logic [15:0]      max_it;
        logic [62:0]      eps;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic         valid;
        logic [2:0]   cluster_index;
        logic [2:0]   coord_pos;
        logic [31:0]  centroid_coord;
        logic [15:0]  passes_done;
        logic         converged;
        logic         empty_cluster;
        logic         last;
    } t_res;

endpackage

`default_nettype wire

[rtl/kmcr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kmcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/kmcr_front.sv]
// Front end: takes command items, drops ignored ones, queues the rest.
// Depends on kmcr_pkg.
`default_nettype none

module kmcr_front import kmcr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [9:0]  i_item_index,
    input  wire logic [2:0]  i_dim_index,
    input  wire logic [31:0] i_coord_value,
    output logic             o_q_valid,
    output t_qent            o_q_ent,
    input  wire logic        i_q_pop
);

    t_qent      r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       keep;
    t_qent      ent;
    logic       push;

    // classify the item
    always_comb begin
        keep    = 1'b0;
        ent.cmd = CMD_RUN;
        ent.idx = PT_W'(i_item_index);
        ent.dim = DM_W'(i_dim_index);
        ent.val = COORD_WIDTH'(i_coord_value);
        unique case (i_req_type)
            REQ_LDPT: begin
                ent.cmd = CMD_LDPT;
                keep    = (int'(i_item_index) < MAX_POINTS) && (int'(i_dim_index) < MAX_DIMS);
            end
            REQ_LDCT: begin
                ent.cmd = CMD_LDCT;
                keep    = (int'(i_item_index) < MAX_CLUSTERS)
                       && (int'(i_dim_index) < MAX_DIMS);
            end
            REQ_RUN: begin
                ent.cmd = CMD_RUN;
                keep    = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_busy    = (r_cnt == 2'd2);
    assign push      = i_start && !o_busy && keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_ent   = r_ent[r_rp];

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_ent[r_wp] <= ent;
                r_wp        <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            if (push && !i_q_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_q_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/kmcr_div.sv]
// Restoring divider, one quotient bit per cycle, for centroid means.
// Depends on kmcr_pkg.
`default_nettype none

module kmcr_div import kmcr_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [SUM_W-1:0] o_quotient,
    output logic      [CNT_W-1:0] o_remainder
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_step;
    logic              r_busy, r_done;
    logic [CNT_W:0]    sh;
    logic              ge;
    logic [CNT_W:0]    diff;

    // one shift-subtract step
    always_comb begin
        sh   = {r_rem, r_quo[SUM_W-1]};
        ge   = (sh >= {1'b0, r_dvs});
        diff = sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_step <= STEP_W'(SUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= ge ? CNT_W'(diff) : CNT_W'(sh);
                r_quo  <= {r_quo[SUM_W-2:0], ge};
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

[rtl/kmcr_back.sv]
// Back end: executes loads and runs Lloyd passes over the stores.
// Depends on kmcr_pkg, kmcr_ram, kmcr_div.
`default_nettype none

module kmcr_back import kmcr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_valid,
    input  wire t_qent i_q_ent,
    output logic       o_q_pop,
    output t_res       o_res
);

    typedef enum logic [4:0] {
        S_IDLE, S_RUN0, S_PRD, S_PWR, S_DRD, S_DOP, S_SUB, S_ABS, S_MUL, S_ACC,
        S_ARD, S_AWR, S_URD, S_UCAP, S_UDIV, S_UVAL, S_PEND, S_ORD, S_OEM
    } t_state;

    t_state                   r_state;
    logic [PT_W-1:0]          r_i;
    logic [CL_W-1:0]          r_c, r_pick;
    logic [DM_W-1:0]          r_j;
    logic signed [COORD_WIDTH-1:0] r_pt [MAX_DIMS];
    logic signed [COORD_WIDTH-1:0] r_opa, r_opb, r_old;
    logic signed [DIF_W-1:0]  r_diff;
    logic [DIF_W-1:0]         r_mag;
    logic [63:0]              r_sq, r_acc, r_best;
    logic                     r_mv, r_allsm, r_conv, r_neg, r_emp_c;
    logic [15:0]              r_pass;
    logic [CNT_W-1:0]         r_cnt [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0]  r_empty;
    logic [NENT-1:0]          r_svld;
    logic [SUM_W-1:0]         r_q;
    t_res                     r_res;

    // store ports
    logic                     pt_we;
    logic [PT_AW-1:0]         pt_waddr;
    logic [COORD_WIDTH-1:0]   pt_rdata;
    logic                     ct_we;
    logic [CT_AW-1:0]         ct_waddr;
    logic [COORD_WIDTH-1:0]   ct_wdata, ct_rdata;
    logic                     sm_we;
    logic [CT_AW-1:0]         sm_raddr;
    logic [SUM_W-1:0]         sm_wdata, sm_rdata;

    logic [CT_AW-1:0]         cj, pj;
    logic signed [SUM_W-1:0]  sum_acc, sum_upd;
    logic [SUM_W-1:0]         sum_mag;
    logic [31:0]              m32;
    logic [63:0]              sq_full;
    logic [64:0]              acc_sum;
    logic [63:0]              acc_new;
    logic                     div_start, div_done;
    logic [SUM_W-1:0]         div_quo, q_rnd;
    logic [CNT_W-1:0]         div_rem, cnt_c;
    logic                     rnd_inc;
    logic [COORD_WIDTH-1:0]   v_new;
    logic [SUM_W-1:0]         v_full;

    assign cj    = {r_c, r_j};
    assign pj    = {r_pick, r_j};
    assign cnt_c = r_cnt[r_c];

    // load commands run straight from the queue head while idle
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign pt_we    = o_q_pop && (i_q_ent.cmd == CMD_LDPT);
    assign pt_waddr = {i_q_ent.idx, i_q_ent.dim};

    // centroid store: loads, or the new mean during the update phase
    always_comb begin
        ct_we    = (o_q_pop && (i_q_ent.cmd == CMD_LDCT)) || (r_state == S_UVAL);
        ct_waddr = (r_state == S_UVAL) ? cj : {CL_W'(i_q_ent.idx), i_q_ent.dim};
        ct_wdata = (r_state == S_UVAL) ? v_new : i_q_ent.val;
    end

    // running sums: entries not yet touched this pass read as zero
    always_comb begin
        sum_acc  = r_svld[pj] ? signed'(sm_rdata) : '0;
        sum_upd  = r_svld[cj] ? signed'(sm_rdata) : '0;
        sm_we    = (r_state == S_AWR);
        sm_raddr = (r_state == S_ARD) ? pj : cj;
        sm_wdata = sum_acc + SUM_W'(r_pt[r_j]);
        sum_mag  = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
    end

    // saturating square and accumulate
    always_comb begin
        m32     = 32'(r_mag);
        sq_full = m32 * m32;
        acc_sum = {1'b0, r_acc} + {1'b0, r_sq};
        if (r_j == '0) begin
            acc_new = r_sq;
        end else begin
            acc_new = acc_sum[64] ? '1 : acc_sum[63:0];
        end
    end

    // mean rounding: nearest, ties away from zero
    always_comb begin
        div_start = (r_state == S_UCAP) && (cnt_c != '0);
        rnd_inc   = (div_rem >= (cnt_c - (cnt_c >> 1)));
        q_rnd     = div_quo + SUM_W'(rnd_inc);
        v_full    = r_neg ? (SUM_W'(0) - r_q) : r_q;
        v_new     = r_emp_c ? '0 : COORD_WIDTH'(v_full);
    end

    kmcr_ram #(.WIDTH(COORD_WIDTH), .DEPTH(NPTENT)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (i_q_ent.val),
        .i_raddr ({r_i, r_j}),
        .o_rdata (pt_rdata)
    );

    kmcr_ram #(.WIDTH(COORD_WIDTH), .DEPTH(NENT)) u_ct_ram (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_waddr (ct_waddr),
        .i_wdata (ct_wdata),
        .i_raddr (cj),
        .o_rdata (ct_rdata)
    );

    kmcr_ram #(.WIDTH(SUM_W), .DEPTH(NENT)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_waddr (pj),
        .i_wdata (sm_wdata),
        .i_raddr (sm_raddr),
        .o_rdata (sm_rdata)
    );

    kmcr_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (sum_mag),
        .i_divisor   (cnt_c),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // run sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_res     <= '0;
            r_pass    <= '0;
            r_conv    <= 1'b0;
            r_empty   <= '0;
            r_svld    <= '0;
            r_mv      <= 1'b0;
            r_allsm   <= 1'b1;
            r_i       <= '0;
            r_c       <= '0;
            r_j       <= '0;
            r_pick    <= '0;
        end else begin
            r_res.valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && (i_q_ent.cmd == CMD_RUN)) begin
                        r_pass  <= '0;
                        r_conv  <= 1'b0;
                        r_empty <= '0;
                        r_c     <= '0;
                        r_j     <= '0;
                        r_state <= (i_cfg.max_it == '0) ? S_ORD : S_RUN0;
                    end
                end
                // start of a pass
                S_RUN0: begin
                    r_svld  <= '0;
                    for (int c = 0; c < MAX_CLUSTERS; c++) begin
                        r_cnt[c] <= '0;
                    end
                    r_allsm <= 1'b1;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_state <= S_PRD;
                end
                // fetch the point into the local copy
                S_PRD: r_state <= S_PWR;
                S_PWR: begin
                    r_pt[r_j] <= signed'(pt_rdata);
                    if (r_j == i_cfg.d_last) begin
                        r_j     <= '0;
                        r_c     <= '0;
                        r_best  <= '1;
                        r_mv    <= 1'b0;
                        r_state <= S_DRD;
                    end else begin
                        r_j     <= r_j + DM_W'(1);
                        r_state <= S_PRD;
                    end
                end
                // distance terms
                S_DRD: r_state <= S_DOP;
                S_DOP: begin
                    r_opa   <= r_pt[r_j];
                    r_opb   <= signed'(ct_rdata);
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_diff  <= DIF_W'(r_opa) - DIF_W'(r_opb);
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_mag   <= r_diff[DIF_W-1] ? DIF_W'(-r_diff) : DIF_W'(r_diff);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_sq    <= (64'(r_mag) > 64'h0000_0000_FFFF_FFFF) ? '1 : sq_full;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= acc_new;
                    if (!r_mv) begin
                        // nearest centroid, later cluster wins ties
                        if (r_j == i_cfg.d_last) begin
                            if (acc_new <= r_best) begin
                                r_best <= acc_new;
                                r_pick <= r_c;
                            end
                            r_j <= '0;
                            if (r_c == i_cfg.k_last) begin
                                r_state <= S_ARD;
                            end else begin
                                r_c     <= r_c + CL_W'(1);
                                r_state <= S_DRD;
                            end
                        end else begin
                            r_j     <= r_j + DM_W'(1);
                            r_state <= S_DRD;
                        end
                    end else begin
                        // centroid movement test
                        if (r_j == i_cfg.d_last) begin
                            if (acc_new >= 64'(i_cfg.eps)) begin
                                r_allsm <= 1'b0;
                            end
                            r_j <= '0;
                            if (r_c == i_cfg.k_last) begin
                                r_state <= S_PEND;
                            end else begin
                                r_c     <= r_c + CL_W'(1);
                                r_state <= S_URD;
                            end
                        end else begin
                            r_j     <= r_j + DM_W'(1);
                            r_state <= S_URD;
                        end
                    end
                end
                // add the point into its cluster's sums
                S_ARD: r_state <= S_AWR;
                S_AWR: begin
                    r_svld[pj] <= 1'b1;
                    if (r_j == i_cfg.d_last) begin
                        r_cnt[r_pick] <= r_cnt[r_pick] + CNT_W'(1);
                        r_j           <= '0;
                        if (r_i == i_cfg.n_last) begin
                            r_c     <= '0;
                            r_state <= S_URD;
                        end else begin
                            r_i     <= r_i + PT_W'(1);
                            r_state <= S_PRD;
                        end
                    end else begin
                        r_j     <= r_j + DM_W'(1);
                        r_state <= S_ARD;
                    end
                end
                // recompute each centroid coordinate
                S_URD: r_state <= S_UCAP;
                S_UCAP: begin
                    r_old        <= signed'(ct_rdata);
                    r_neg        <= sum_upd[SUM_W-1];
                    r_emp_c      <= (cnt_c == '0);
                    r_empty[r_c] <= (cnt_c == '0);
                    r_state      <= (cnt_c == '0) ? S_UVAL : S_UDIV;
                end
                S_UDIV: begin
                    if (div_done) begin
                        r_q     <= q_rnd;
                        r_state <= S_UVAL;
                    end
                end
                S_UVAL: begin
                    r_opa   <= signed'(v_new);
                    r_opb   <= r_old;
                    r_mv    <= 1'b1;
                    r_state <= S_SUB;
                end
                // end of pass
                S_PEND: begin
                    r_pass <= r_pass + 16'd1;
                    r_c    <= '0;
                    r_j    <= '0;
                    if (r_allsm) begin
                        r_conv  <= 1'b1;
                        r_state <= S_ORD;
                    end else if (({1'b0, r_pass} + 17'd1) < {1'b0, i_cfg.max_it}) begin
                        r_state <= S_RUN0;
                    end else begin
                        r_state <= S_ORD;
                    end
                end
                // report final centroids, cluster-major
                S_ORD: r_state <= S_OEM;
                S_OEM: begin
                    r_res.valid          <= 1'b1;
                    r_res.cluster_index  <= 3'(r_c);
                    r_res.coord_pos      <= 3'(r_j);
                    r_res.centroid_coord <= 32'(ct_rdata);
                    r_res.passes_done    <= r_pass;
                    r_res.converged      <= r_conv;
                    r_res.empty_cluster  <= r_empty[r_c];
                    r_res.last           <= (r_c == i_cfg.k_last) && (r_j == i_cfg.d_last);
                    if (r_j == i_cfg.d_last) begin
                        r_j <= '0;
                        if (r_c == i_cfg.k_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_c     <= r_c + CL_W'(1);
                            r_state <= S_ORD;
                        end
                    end else begin
                        r_j     <= r_j + DM_W'(1);
                        r_state <= S_ORD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[rtl/kmeans_cluster_refine.sv]
// Top level of the Lloyd k-means refinement block: config registers,
// front queue and back sequencer. Depends on kmcr_pkg, kmcr_front, kmcr_back.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  command  | i_start / o_busy           | i_req_type i_item_index i_dim_index
//           |                            | i_coord_value
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//  result   | o_valid (one-cycle strobe) | o_cluster_index o_coord_pos
//           |                            | o_centroid_coord o_passes_done
//           |                            | o_converged o_empty_cluster o_last
//
// Load items are written to the stores as they leave the queue and stream
// at one per cycle while no run is in progress. A run's passes are paced by
// the shared square/accumulate unit and the bit-serial divider; a coordinate
// of an empty cluster skips the divider. Each result is read from the
// centroid store and then emitted. Reset is synchronous; stores need no
// clearing pass. Results cannot be stalled; commands queue two deep while a
// run is in progress.
`default_nettype none
`include "kmeans_cluster_refine_macros.svh"

module kmeans_cluster_refine import kmcr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [9:0]  i_item_index,
    input  wire logic [2:0]  i_dim_index,
    input  wire logic [31:0] i_coord_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    output logic             o_valid,
    output logic [2:0]       o_cluster_index,
    output logic [2:0]       o_coord_pos,
    output logic [31:0]      o_centroid_coord,
    output logic [15:0]      o_passes_done,
    output logic             o_converged,
    output logic             o_empty_cluster,
    output logic             o_last
);

    typedef enum logic [2:0] {
        CFG_NPTS  = 3'd0,
        CFG_NCL   = 3'd1,
        CFG_NDIM  = 3'd2,
        CFG_MAXIT = 3'd3,
        CFG_EPS   = 3'd4
    } t_cfg_idx;

    logic [10:0] r_num_points;
    logic [3:0]  r_num_clusters;
    logic [3:0]  r_num_dims;
    logic [15:0] r_max_it;
    logic [62:0] r_eps;
    t_cfg        cfg;
    logic        q_valid, q_pop;
    t_qent       q_ent;
    t_res        res;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points   <= 11'd1024;
            r_num_clusters <= 4'd8;
            r_num_dims     <= 4'd8;
            r_max_it       <= 16'd300;
            r_eps          <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NPTS:  r_num_points   <= i_cfg_data[10:0];
                CFG_NCL:   r_num_clusters <= i_cfg_data[3:0];
                CFG_NDIM:  r_num_dims     <= i_cfg_data[3:0];
                CFG_MAXIT: r_max_it       <= i_cfg_data[15:0];
                CFG_EPS:   r_eps          <= i_cfg_data[62:0];
                default: ;
            endcase
        end
    end

    // clamp counts to [1, max] and hand over last indexes
    always_comb begin
        if (r_num_points == '0) begin
            cfg.n_last = '0;
        end else if (int'(r_num_points) > MAX_POINTS) begin
            cfg.n_last = PT_W'(MAX_POINTS - 1);
        end else begin
            cfg.n_last = PT_W'(r_num_points - 11'd1);
        end
        if (r_num_clusters == '0) begin
            cfg.k_last = '0;
        end else if (int'(r_num_clusters) > MAX_CLUSTERS) begin
            cfg.k_last = CL_W'(MAX_CLUSTERS - 1);
        end else begin
            cfg.k_last = CL_W'(r_num_clusters - 4'd1);
        end
        if (r_num_dims == '0) begin
            cfg.d_last = '0;
        end else if (int'(r_num_dims) > MAX_DIMS) begin
            cfg.d_last = DM_W'(MAX_DIMS - 1);
        end else begin
            cfg.d_last = DM_W'(r_num_dims - 4'd1);
        end
        cfg.max_it = r_max_it;
        cfg.eps    = r_eps;
    end

    kmcr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_req_type    (i_req_type),
        .i_item_index  (i_item_index),
        .i_dim_index   (i_dim_index),
        .i_coord_value (i_coord_value),
        .o_q_valid     (q_valid),
        .o_q_ent       (q_ent),
        .i_q_pop       (q_pop)
    );

    kmcr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_ent   (q_ent),
        .o_q_pop   (q_pop),
        .o_res     (res)
    );

    assign o_valid          = res.valid;
    assign o_cluster_index  = res.cluster_index;
    assign o_coord_pos      = res.coord_pos;
    assign o_centroid_coord = res.centroid_coord;
    assign o_passes_done    = res.passes_done;
    assign o_converged      = res.converged;
    assign o_empty_cluster  = res.empty_cluster;
    assign o_last           = res.last;

    // checks
    `KMCR_ASSERT_NXT(a_last_ends_run, o_valid && o_last, !o_valid, "result after last")
    `KMCR_ASSERT_IMP(a_conv_needs_pass, o_valid && o_converged, o_passes_done != 16'd0, "converged with no pass")
    `KMCR_ASSERT_IMP(a_empty_needs_pass, o_valid && o_empty_cluster, o_passes_done != 16'd0, "empty flag with no pass")

endmodule

`default_nettype wire
